FILE: hw/rtl/mrrp_pkg.sv
package mrrp_pkg;

  // Ring geometry and record limits
  localparam int unsigned RING_BYTES       = 65536;
  localparam int unsigned READER_COUNT     = 4;
  localparam int unsigned MAX_RECORD_BYTES = 4096;
  localparam int unsigned HEADER_BYTES     = 16;

  localparam int unsigned POS_W  = 17;          // 0 .. RING_BYTES
  localparam int unsigned RD_W   = 2;           // reader number
  localparam int unsigned PLEN_W = 16;          // payload length field
  localparam int unsigned LEN_W  = 17;          // payload + header
  localparam int unsigned REC_W  = 13;          // record_length field
  localparam int unsigned SUM_W  = 18;          // position + length
  localparam int unsigned EN_W   = 4;           // reader_enable register

  localparam logic [EN_W-1:0] ENABLE_RESET = 4'hF;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_ERROR    = 3'd3,
    ST_CRITICAL = 3'd4
  } status_t;

  typedef struct packed {
    mode_t             mode;
    logic [RD_W-1:0]   reader;
    logic [PLEN_W-1:0] payload_length;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] offset;
    logic [REC_W-1:0] record_length;
    logic [POS_W-1:0] remaining;
  } out_result_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch request and slowest reader
    logic execute;  // resolve request, commit pointers, drive result
  } dp_cmd_t;

endpackage

FILE: hw/rtl/multi_reader_record_ring_pointers_top.sv
// Channel   Ports                          Handshake
// -------   -----------------------------  ----------------------------------
// input     start, busy, in_item           beat taken when start && !busy
// result    out_valid, out_result          one-cycle strobe, cannot stall
// config    cfg_we, cfg_wdata              reader_enable written when cfg_we
//
// On an accepted beat the accept edge latches the request and the slowest
// enabled reader; the next edge resolves it, commits pointers and raises
// out_valid for one cycle. A new beat can be taken on that same cycle; no beat
// is taken while the single execute state is busy with the last one.
// Synchronous active-low reset: all positions 0, reader_enable = 4'hF.
// The result side never stalls; busy only reflects the execute cycle.
module multi_reader_record_ring_pointers_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  mrrp_pkg::in_item_t          in_item,
  output logic                        out_valid,
  output mrrp_pkg::out_result_t       out_result,
  input  logic                        cfg_we,
  input  logic [mrrp_pkg::EN_W-1:0]   cfg_wdata
);

  mrrp_pkg::dp_cmd_t cmd;

  // sequencer: idle -> execute -> idle
  mrrp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // pointer registers, slowest-reader search, write/read resolution
  mrrp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

FILE: hw/rtl/mrrp_ctrl.sv
module mrrp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output mrrp_pkg::dp_cmd_t cmd
);

  mrrp_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrrp_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrrp_pkg::CS_IDLE: begin
        if (start) begin
          state_nxt = mrrp_pkg::CS_EXEC;
        end
      end
      mrrp_pkg::CS_EXEC: begin
        state_nxt = mrrp_pkg::CS_IDLE;
      end
      default: begin
        state_nxt = mrrp_pkg::CS_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      mrrp_pkg::CS_IDLE: begin
        cmd.capture = start;
      end
      mrrp_pkg::CS_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mrrp_dp.sv
module mrrp_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mrrp_pkg::dp_cmd_t            cmd,
  input  mrrp_pkg::in_item_t           in_item,
  input  logic                         cfg_we,
  input  logic [mrrp_pkg::EN_W-1:0]    cfg_wdata,
  output logic                         out_valid,
  output mrrp_pkg::out_result_t        out_result
);

  localparam logic [mrrp_pkg::POS_W-1:0] RING_P = mrrp_pkg::POS_W'(mrrp_pkg::RING_BYTES);
  localparam logic [mrrp_pkg::SUM_W-1:0] RING_S = mrrp_pkg::SUM_W'(mrrp_pkg::RING_BYTES);
  localparam logic [mrrp_pkg::LEN_W-1:0] MAX_L  =
    mrrp_pkg::LEN_W'(mrrp_pkg::MAX_RECORD_BYTES);
  localparam logic [mrrp_pkg::LEN_W-1:0] RING_L = mrrp_pkg::LEN_W'(mrrp_pkg::RING_BYTES);

  // pointer state
  logic [mrrp_pkg::EN_W-1:0]  en_r;
  logic [mrrp_pkg::POS_W-1:0] wp_r, wp_nxt;
  logic [mrrp_pkg::POS_W-1:0] end_r, end_nxt;
  logic [mrrp_pkg::POS_W-1:0] rp_r [mrrp_pkg::READER_COUNT];
  logic [mrrp_pkg::POS_W-1:0] rp_nxt;
  logic                       rp_we;

  // captured request
  mrrp_pkg::mode_t            mode_r;
  logic [mrrp_pkg::RD_W-1:0]  rd_r;
  logic [mrrp_pkg::LEN_W-1:0] len_r;
  logic [mrrp_pkg::POS_W-1:0] last_r, last_nxt;
  logic [mrrp_pkg::POS_W-1:0] rps_r;

  logic                        out_valid_r;
  mrrp_pkg::out_result_t       res_r, res_nxt;

  // slowest enabled reader: lowest position ahead of wp, else lowest behind
  logic [mrrp_pkg::POS_W-1:0] left_min, right_min;

  always_comb begin
    left_min  = RING_P;
    right_min = RING_P;
    for (int i = 0; i < mrrp_pkg::READER_COUNT; i++) begin
      if (en_r[i]) begin
        if (rp_r[i] <= wp_r) begin
          if (rp_r[i] < left_min) left_min = rp_r[i];
        end else if (rp_r[i] < right_min) begin
          right_min = rp_r[i];
        end
      end
    end
    last_nxt = (right_min == RING_P) ? left_min : right_min;
  end

  // execute step
  logic [mrrp_pkg::SUM_W-1:0] w_sum, r_sum;
  logic [mrrp_pkg::POS_W-1:0] rp1, to_read;
  logic                       w_err, full0, wraps, full1;
  logic                       jump, back;

  always_comb begin
    wp_nxt  = wp_r;
    end_nxt = end_r;
    rp_we   = 1'b0;
    rp_nxt  = rps_r;
    res_nxt = '{status: mrrp_pkg::ST_OK, offset: '0, record_length: '0, remaining: '0};

    w_sum = {1'b0, wp_r} + {1'b0, len_r};
    w_err = (wp_r > RING_P) || (len_r > MAX_L) || (len_r > RING_L);
    full0 = (wp_r < last_r) && (w_sum >= {1'b0, last_r});
    wraps = w_sum > RING_S;
    full1 = (last_r != '0) && ({1'b0, len_r} >= {1'b0, last_r});

    jump    = (wp_r < rps_r) && (end_r == rps_r);
    rp1     = jump ? '0 : rps_r;
    back    = wp_r < rp1;
    to_read = back ? (end_r - rp1) : (wp_r - rp1);
    r_sum   = {1'b0, rp1} + {1'b0, len_r};

    if (mode_r == mrrp_pkg::MODE_WRITE) begin
      if (w_err) begin
        res_nxt.status = mrrp_pkg::ST_ERROR;
      end else if (full0) begin
        res_nxt.status = mrrp_pkg::ST_FULL;
      end else if (wraps) begin
        // wrap sticks even when the retry at zero is full
        end_nxt = wp_r;
        wp_nxt  = '0;
        if (full1) begin
          res_nxt.status = mrrp_pkg::ST_FULL;
        end else begin
          res_nxt.record_length = len_r[mrrp_pkg::REC_W-1:0];
          wp_nxt                = len_r;
        end
      end else begin
        res_nxt.offset        = wp_r;
        res_nxt.record_length = len_r[mrrp_pkg::REC_W-1:0];
        wp_nxt                = w_sum[mrrp_pkg::POS_W-1:0];
      end
    end else begin
      if ((wp_r > RING_P) || (rps_r > RING_P)) begin
        res_nxt.status = mrrp_pkg::ST_ERROR;
      end else begin
        if (jump) begin
          rp_we  = 1'b1;
          rp_nxt = '0;
        end
        if (wp_r == rp1) begin
          res_nxt.status = mrrp_pkg::ST_EMPTY;
        end else if (back && (end_r < rp1)) begin
          res_nxt.status = mrrp_pkg::ST_CRITICAL;
        end else if (len_r > MAX_L) begin
          res_nxt.status = mrrp_pkg::ST_ERROR;
        end else if (!back && ({1'b0, wp_r} < r_sum)) begin
          res_nxt.status = mrrp_pkg::ST_ERROR;
          rp_we          = 1'b1;
          rp_nxt         = wp_r;
        end else if (back && ({1'b0, end_r} < r_sum)) begin
          res_nxt.status = mrrp_pkg::ST_ERROR;
          rp_we          = 1'b1;
          rp_nxt         = end_r;
        end else begin
          rp_we                 = 1'b1;
          rp_nxt                = r_sum[mrrp_pkg::POS_W-1:0];
          res_nxt.offset        = rp1;
          res_nxt.record_length = len_r[mrrp_pkg::REC_W-1:0];
          res_nxt.remaining     = to_read - len_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= mrrp_pkg::ENABLE_RESET;
      wp_r        <= '0;
      end_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mrrp_pkg::READER_COUNT; i++) begin
        rp_r[i] <= '0;
      end
    end else begin
      out_valid_r <= cmd.execute;
      if (cfg_we) begin
        en_r <= cfg_wdata;
      end
      if (cmd.execute) begin
        wp_r  <= wp_nxt;
        end_r <= end_nxt;
        if (rp_we) begin
          rp_r[rd_r] <= rp_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_item.mode;
      rd_r   <= in_item.reader;
      len_r  <= {1'b0, in_item.payload_length} + mrrp_pkg::LEN_W'(mrrp_pkg::HEADER_BYTES);
      last_r <= last_nxt;
      rps_r  <= rp_r[in_item.reader];
    end
    if (cmd.execute) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = res_r;

endmodule

FILE: hw/rtl/mrrp_checker.sv
module mrrp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input mrrp_pkg::out_result_t out_result
);

  // every accepted beat yields a result once its execute state ends
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing after accepted beat");

  // no back-to-back strobes
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held");

  // busy is never asserted back to back
  a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held");

  // refused requests carry zero payload
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result.status != mrrp_pkg::ST_OK)) |->
      ((out_result.offset == '0) && (out_result.record_length == '0) &&
       (out_result.remaining == '0)))
    else $error("nonzero fields on failed result");

endmodule

bind multi_reader_record_ring_pointers_top mrrp_checker u_mrrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_result (out_result)
);
